@@ sv/deq_pkg.sv @@
// Shared types and codes for the double-ended queue.
`default_nettype none

package deq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_out;
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        count_out;
   } rsp_type;

   // result stage state, handed from control to the output side
   typedef struct packed {
      logic                valid;
      logic                is_read;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count_out;
   } rsp_info_type;

endpackage

`default_nettype wire

@@ sv/deq_mem.sv @@
// Slot storage: single-port synchronous RAM, registered read.
`default_nettype none

module deq_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[addr];
      end
   end

endmodule

`default_nettype wire

@@ sv/deq_ctrl.sv @@
// Ring pointers, count, operation decode and result stage.
`default_nettype none

module deq_ctrl #(
   parameter int DEPTH      = 16,
   parameter int STORE_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire deq_pkg::req_type         req,
   input  wire logic                     rsp_ready,
   output deq_pkg::rsp_info_type         info,
   output logic                          mem_wr_en,
   output logic                          mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]      mem_addr,
   output logic [STORE_BITS-1:0]         mem_wr_data
);

   import deq_pkg::*;

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int SUM_BITS = PTR_BITS + 1;

   localparam logic [CNT_BITS-1:0] CNT_FULL  = CNT_BITS'(DEPTH);
   localparam logic [SUM_BITS-1:0] SUM_DEPTH = SUM_BITS'(DEPTH);
   localparam logic [PTR_BITS-1:0] PTR_LAST  = PTR_BITS'(DEPTH - 1);

   logic [PTR_BITS-1:0] front_ff, front_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   rsp_info_type        info_ff, info_in;

   logic                accept;
   logic                full, empty;
   logic [PTR_BITS-1:0] back_ptr, last_ptr, prev_front, next_front;
   logic [SUM_BITS-1:0] back_sum, last_sum, next_sum;
   logic [STATUS_W-1:0] status;

   assign req_ready = !info_ff.valid || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_FULL);
   assign empty     = (count_ff == '0);

   // ring positions without a divider: one compare and subtract
   assign back_sum   = SUM_BITS'(front_ff) + SUM_BITS'(count_ff);
   assign last_sum   = back_sum - SUM_BITS'(1);
   assign next_sum   = SUM_BITS'(front_ff) + SUM_BITS'(1);
   assign back_ptr   = (back_sum >= SUM_DEPTH) ? PTR_BITS'(back_sum - SUM_DEPTH)
                                               : PTR_BITS'(back_sum);
   assign last_ptr   = (last_sum >= SUM_DEPTH) ? PTR_BITS'(last_sum - SUM_DEPTH)
                                               : PTR_BITS'(last_sum);
   assign next_front = (next_sum >= SUM_DEPTH) ? '0 : PTR_BITS'(next_sum);
   assign prev_front = (front_ff == '0) ? PTR_LAST : front_ff - PTR_BITS'(1);

   assign mem_wr_data = req.value_in[STORE_BITS-1:0];

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      mem_wr_en = 1'b0;
      mem_rd_en = 1'b0;
      mem_addr  = front_ff;
      status    = ST_OK;
      if (accept) begin
         unique case (req.op) inside
            OP_PUSH_BACK: begin
               if (full) begin
                  status = ST_FULL;
               end else begin
                  mem_wr_en = 1'b1;
                  mem_addr  = back_ptr;
                  count_in  = count_ff + CNT_BITS'(1);
               end
            end
            OP_PUSH_FRONT: begin
               if (full) begin
                  status = ST_FULL;
               end else begin
                  mem_wr_en = 1'b1;
                  mem_addr  = prev_front;
                  front_in  = prev_front;
                  count_in  = count_ff + CNT_BITS'(1);
               end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
               if (empty) begin
                  status = ST_EMPTY;
               end else begin
                  mem_rd_en = 1'b1;
                  mem_addr  = front_ff;
                  if (req.op == OP_POP_FRONT) begin
                     front_in = next_front;
                     count_in = count_ff - CNT_BITS'(1);
                  end
               end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
               if (empty) begin
                  status = ST_EMPTY;
               end else begin
                  mem_rd_en = 1'b1;
                  mem_addr  = last_ptr;
                  if (req.op == OP_POP_BACK) begin
                     count_in = count_ff - CNT_BITS'(1);
                  end
               end
            end
            default: begin
               // unused codes: no operation
            end
         endcase
      end
   end

   always_comb begin
      info_in = info_ff;
      if (accept) begin
         info_in.valid     = 1'b1;
         info_in.is_read   = mem_rd_en;
         info_in.status    = status;
         info_in.count_out = COUNT_W'(count_in);
      end else if (rsp_ready) begin
         info_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         info_ff  <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         info_ff  <= info_in;
      end
   end

   assign info = info_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("count above depth");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      SUM_BITS'(front_ff) < SUM_DEPTH)
      else $error("front pointer outside ring");

   a_full_push_holds: assert property (@(posedge clock) disable iff (reset)
      accept && full && (req.op == OP_PUSH_BACK || req.op == OP_PUSH_FRONT)
      |=> $stable(count_ff) && $stable(front_ff))
      else $error("push on full queue changed state");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      accept && !empty && (req.op == OP_POP_FRONT || req.op == OP_POP_BACK)
      |=> count_ff == $past(count_ff) - CNT_BITS'(1))
      else $error("pop did not remove one value");

   a_read_has_data: assert property (@(posedge clock) disable iff (reset)
      info_ff.valid && info_ff.is_read |-> info_ff.status == ST_OK)
      else $error("read result with error status");

endmodule

`default_nettype wire

@@ sv/double_ended_queue.sv @@
// Top level of the double-ended queue: control, slot RAM and result output.
//
//   channel | ports                             | beat
//   --------+-----------------------------------+------------------------------
//   request | req_valid, req_ready, req_data    | one operation: op, value_in
//   result  | rsp_valid, rsp_ready, rsp_data    | value_out, status, count_out
//
// One beat per cycle sustained while results are taken; a result is offered in the cycle after
// its request beat, matching the registered read of the slot RAM.
// Pointers and count update when the request is taken, so back-to-back
// operations see each other without forwarding.
// Reset clears pointers, count and the result stage; slots are not cleared.
// A stalled result blocks the next request only while it is not taken.
`default_nettype none

module double_ended_queue #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int VALUE_BITS = deq_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire deq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output deq_pkg::rsp_type      rsp_data
);

   import deq_pkg::*;

   localparam int STORE_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
   localparam int PTR_BITS   = $clog2(DEPTH);

   rsp_info_type                 info;
   logic                         mem_wr_en, mem_rd_en;
   logic [PTR_BITS-1:0]          mem_addr;
   logic [STORE_BITS-1:0]        mem_wr_data;
   logic signed [STORE_BITS-1:0] mem_rd_data;

   deq_ctrl #(
      .DEPTH      (DEPTH),
      .STORE_BITS (STORE_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req_data),
      .rsp_ready   (rsp_ready),
      .info        (info),
      .mem_wr_en   (mem_wr_en),
      .mem_rd_en   (mem_rd_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data)
   );

   deq_mem #(
      .DEPTH (DEPTH),
      .WIDTH (STORE_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // read data holds in the RAM output register while the result stalls
   assign rsp_valid          = info.valid;
   assign rsp_data.value_out = info.is_read ? VALUE_W'(mem_rd_data) : '0;
   assign rsp_data.status    = info.status;
   assign rsp_data.count_out = info.count_out;

endmodule

`default_nettype wire

@@ dv/tb_double_ended_queue.sv @@
// Self-checking testbench for double_ended_queue: directed table, then biased random ops.
`timescale 1ns / 1ps

module tb_double_ended_queue;
   import deq_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int PTR_BITS    = $clog2(DEPTH);
   localparam int STALL_LIMIT = 1000;
   localparam int RAND_ITEMS  = 515;

   // op codes the block treats as no-ops
   localparam logic [OP_W-1:0] OP_NOP_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_NOP_7 = 3'd7;

   typedef enum int {FILLING, DRAINING, CHURN} bias_type;

   typedef struct {
      req_type beat;
      int      reps;
      bit      fresh_value;
      bit      typed;
      rsp_type want;
   } plan_row_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // literal expectation riding along with the request beat
   logic    typed_on = 1'b0;
   rsp_type typed_rsp = '0;

   // queue contents as the predictor sees them
   logic signed [VALUE_W-1:0] ring_vals [DEPTH];
   logic [PTR_BITS-1:0]       head_pos = '0;
   logic [COUNT_W-1:0]        fill = '0;

   rsp_type pending_rsps [$];
   int      errors = 0;
   int      send_idle = 17;
   int      recv_idle = 53;
   int      stall_cycles = 0;
   plan_row_type plan [15];

   double_ended_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type deque_apply(input req_type r);
      rsp_type             o;
      logic [PTR_BITS-1:0] slot;
      o = '0;
      case (r.op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (fill == COUNT_W'(DEPTH)) begin
               o.status = ST_FULL;
            end else if (r.op == OP_PUSH_BACK) begin
               slot = head_pos + PTR_BITS'(fill);
               ring_vals[slot] = r.value_in;
               fill = fill + COUNT_W'(1);
            end else begin
               head_pos = head_pos - PTR_BITS'(1);
               ring_vals[head_pos] = r.value_in;
               fill = fill + COUNT_W'(1);
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (fill == '0) begin
               o.status = ST_EMPTY;
            end else begin
               if (r.op == OP_POP_FRONT || r.op == OP_PEEK_FRONT)
                  slot = head_pos;
               else
                  slot = head_pos + PTR_BITS'(fill - COUNT_W'(1));
               o.value_out = ring_vals[slot];
               if (r.op == OP_POP_FRONT) begin
                  head_pos = head_pos + PTR_BITS'(1);
                  fill = fill - COUNT_W'(1);
               end else if (r.op == OP_POP_BACK) begin
                  fill = fill - COUNT_W'(1);
               end
            end
         end
         default: ;
      endcase
      o.count_out = fill;
      return o;
   endfunction

   function automatic plan_row_type plan_row(input logic [OP_W-1:0] op,
                                             input logic signed [VALUE_W-1:0] v,
                                             input int reps, input bit fresh,
                                             input bit typed,
                                             input logic signed [VALUE_W-1:0] wv,
                                             input logic [STATUS_W-1:0] ws,
                                             input int wc);
      plan_row_type p;
      p.beat.op         = op;
      p.beat.value_in   = v;
      p.reps            = reps;
      p.fresh_value     = fresh;
      p.typed           = typed;
      p.want.value_out  = wv;
      p.want.status     = ws;
      p.want.count_out  = COUNT_W'(wc);
      return p;
   endfunction

   function automatic req_type pick_beat(input bias_type mode);
      req_type b;
      int      r;
      int      push_pct;
      r = $urandom_range(99);
      push_pct = (mode == FILLING) ? 75 : (mode == DRAINING) ? 20 : 45;
      if (r < 3) begin
         b.op = $urandom_range(1) ? OP_NOP_6 : OP_NOP_7;
      end else if (r < 3 + push_pct) begin
         b.op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
         case ($urandom_range(5))
            0, 1:    b.op = OP_POP_FRONT;
            2, 3:    b.op = OP_POP_BACK;
            4:       b.op = OP_PEEK_FRONT;
            default: b.op = OP_PEEK_BACK;
         endcase
      end
      case ($urandom_range(7))
         0:       b.value_in = 32'sh7FFFFFFF;
         1:       b.value_in = 32'sh80000000;
         2:       b.value_in = -32'sd1;
         3:       b.value_in = '0;
         default: b.value_in = $urandom;
      endcase
      return b;
   endfunction

   // one request beat; returns in the time step of the accepting edge
   task automatic send_beat(input req_type beat, input bit typed, input rsp_type want);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      typed_on  <= typed;
      typed_rsp <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic run_random(input int items);
      bias_type mode;
      int       left;
      int       sent;
      req_type  b;
      mode = CHURN;
      left = 0;
      sent = 0;
      while (sent < items) begin
         if (left == 0) begin
            mode = bias_type'($urandom_range(2));
            left = $urandom_range(8, 40);
         end
         b = pick_beat(mode);
         send_beat(b, 1'b0, '0);
         left--;
         if (b.op != OP_NOP_6 && b.op != OP_NOP_7) sent++;
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin : scoreboard
      rsp_type predicted;
      rsp_type e;
      if (!reset) begin
         // predict first: the new beat goes to the back, so order is safe
         if (req_valid && req_ready) begin
            predicted = deque_apply(req_data);
            pending_rsps.push_back(typed_on ? typed_rsp : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsps.size() == 0) begin
               $error("rsp beat with nothing expected: value_out %0d status %0d count_out %0d",
                      rsp_data.value_out, rsp_data.status, rsp_data.count_out);
               errors++;
            end else begin
               e = pending_rsps.pop_front();
               if (rsp_data.value_out !== e.value_out) begin
                  $error("value_out: expected %0d, got %0d", e.value_out, rsp_data.value_out);
                  errors++;
               end
               if (rsp_data.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.count_out !== e.count_out) begin
                  $error("count_out: expected %0d, got %0d", e.count_out, rsp_data.count_out);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("tb_double_ended_queue: done, errors");
            $finish;
         end
      end
   end

   initial begin : stimulus
      req_type b;
      plan[0]  = plan_row(OP_POP_FRONT,  '0, 1, 0, 1, '0, ST_EMPTY, 0);
      plan[1]  = plan_row(OP_PEEK_BACK,  '0, 1, 0, 1, '0, ST_EMPTY, 0);
      plan[2]  = plan_row(OP_NOP_6,      -32'sd1, 1, 0, 1, '0, ST_OK, 0);
      plan[3]  = plan_row(OP_PUSH_BACK,  32'sh7FFFFFFF, 1, 0, 1, '0, ST_OK, 1);
      // single pop empties the queue
      plan[4]  = plan_row(OP_POP_BACK,   '0, 1, 0, 1, 32'sh7FFFFFFF, ST_OK, 0);
      plan[5]  = plan_row(OP_POP_BACK,   '0, 1, 0, 1, '0, ST_EMPTY, 0);
      plan[6]  = plan_row(OP_PUSH_FRONT, 32'sh80000000, 1, 0, 1, '0, ST_OK, 1);
      plan[7]  = plan_row(OP_PUSH_BACK,  -32'sd1, 1, 0, 1, '0, ST_OK, 2);
      plan[8]  = plan_row(OP_PEEK_FRONT, '0, 1, 0, 1, 32'sh80000000, ST_OK, 2);
      plan[9]  = plan_row(OP_PEEK_BACK,  '0, 1, 0, 1, -32'sd1, ST_OK, 2);
      plan[10] = plan_row(OP_PUSH_FRONT, '0, DEPTH - 2, 1, 0, '0, ST_OK, 0);
      plan[11] = plan_row(OP_PUSH_BACK,  32'sd1, 1, 0, 1, '0, ST_FULL, DEPTH);
      plan[12] = plan_row(OP_PUSH_FRONT, '0, 1, 0, 1, '0, ST_FULL, DEPTH);
      plan[13] = plan_row(OP_NOP_7,      '0, 1, 0, 1, '0, ST_OK, DEPTH);
      plan[14] = plan_row(OP_POP_FRONT,  '0, 1, 0, 0, '0, ST_OK, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 15; i++) begin
         for (int k = 0; k < plan[i].reps; k++) begin
            b = plan[i].beat;
            if (plan[i].fresh_value) b.value_in = $urandom;
            send_beat(b, plan[i].typed, plan[i].want);
         end
      end

      run_random(RAND_ITEMS);
      send_idle = 53;
      recv_idle = 17;
      run_random(RAND_ITEMS);
      send_idle = 0;
      recv_idle = 0;
      run_random(RAND_ITEMS);
      req_valid <= 1'b0;

      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("tb_double_ended_queue: done, clean");
      else
         $display("tb_double_ended_queue: done, errors");
      $finish;
   end

endmodule
